>>> hw/rtl/adsr_pkg.sv
// adsr_pkg: shared types and constants for the adsr envelope generator
// used by adsr_ctrl, adsr_dp and adsr_envelope_generator_core
`timescale 1ns / 1ps
package adsr_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] MODE_EXP    = 3'd0;
   localparam logic [2:0] MODE_PARAB  = 3'd1;
   localparam logic [2:0] MODE_LINEAR = 3'd2;
   localparam logic [2:0] MODE_INST   = 3'd3;

   localparam logic [2:0] REG_PEAK  = 3'd0;
   localparam logic [2:0] REG_FLOOR = 3'd1;
   localparam logic [2:0] REG_ATK   = 3'd2;
   localparam logic [2:0] REG_DEC   = 3'd3;
   localparam logic [2:0] REG_HOLD  = 3'd4;
   localparam logic [2:0] REG_RATE  = 3'd5;
   localparam logic [2:0] REG_MODE  = 3'd6;

   localparam int EXP_TABLE_DEPTH = 256;
   // exp(-16 / 256) in q32 from the truncated alternating series
   localparam logic [63:0] EXP_RATIO = 64'd4034748382;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture input transaction
      logic div_start;
      logic div_sel;  // 0 attack, 1 decay
      logic div_store;
      logic mul_step; // one step of tick arithmetic
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic trig_up;
      logic need_decay;
      logic is_tick;
      logic is_trig;
   } sts_type;

   // e(k) = 65536 * exp(-16 k / depth), rounded like the integer table build
   function automatic logic [16:0] exp_entry(input int unsigned k);
      logic [63:0] acc;
      logic [63:0] e;
      logic [127:0] p;
      acc = 64'd1 << 32;
      for (int unsigned j = 0; j < k; j++) begin
         p = 128'(acc) * 128'(EXP_RATIO);
         acc = p[95:32];
      end
      e = (acc + 64'd32768) >> 16;
      if (e > 64'd65536) e = 64'd65536;
      return e[16:0];
   endfunction

endpackage

>>> hw/rtl/adsr_div.sv
// adsr_div: restoring divider for slope computation, one quotient bit a cycle
// standalone, no package dependency
`timescale 1ns / 1ps
module adsr_div #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quo
);
   localparam int CW = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0] r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff, d_in;
   logic [CW-1:0] c_ff, c_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS+1:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      c_in = c_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[NUM_BITS-1]} - {2'b0, d_ff};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         c_in = CW'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_BITS+1]) begin
            r_in = trial[DEN_BITS:0];
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         c_in = c_ff - CW'(1);
         if (c_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      c_ff <= c_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule

>>> hw/rtl/adsr_ctrl.sv
// adsr_ctrl: sequencer for one transaction at a time
// depends on adsr_pkg
`timescale 1ns / 1ps
module adsr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output adsr_pkg::cmd_type cmd,
   input  adsr_pkg::sts_type sts
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_DEC   = 8'b00000010,
      S_DIVA  = 8'b00000100,
      S_DIVD  = 8'b00001000,
      S_T0    = 8'b00010000,
      S_T1    = 8'b00100000,
      S_T2    = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               st_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.is_trig && sts.trig_up) begin
               cmd.div_start = 1'b1;
               st_in = S_DIVA;
            end else if (sts.is_tick) begin
               st_in = S_T0;
            end else begin
               cmd.commit = 1'b1;
               st_in = S_OUT;
            end
         end
         S_DIVA: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (sts.need_decay) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel = 1'b1;
                  st_in = S_DIVD;
               end else begin
                  cmd.commit = 1'b1;
                  st_in = S_OUT;
               end
            end
         end
         S_DIVD: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               cmd.commit = 1'b1;
               st_in = S_OUT;
            end
         end
         S_T0: begin
            cmd.mul_step = 1'b1;
            st_in = S_T1;
         end
         S_T1: begin
            cmd.mul_step = 1'b1;
            st_in = S_T2;
         end
         S_T2: begin
            cmd.commit = 1'b1;
            st_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end
endmodule

>>> hw/rtl/adsr_dp.sv
// adsr_dp: envelope state, configuration registers and arithmetic
// depends on adsr_pkg and adsr_div
`timescale 1ns / 1ps
module adsr_dp (
   input  logic             clock,
   input  logic             reset,
   input  adsr_pkg::cmd_type cmd,
   output adsr_pkg::sts_type sts,
   input  logic [1:0]       op,
   input  logic [15:0]      trigger_level,
   input  logic [7:0]       tick_length,
   input  logic             cfg_we,
   input  logic [2:0]       cfg_idx,
   input  logic [31:0]      cfg_data,
   output logic [31:0]      cfg_rdata,
   output logic [15:0]      level,
   output logic             running,
   output logic             holding
);
   localparam int XB = $clog2(adsr_pkg::EXP_TABLE_DEPTH);

   logic [15:0] peak_ff, floor_ff, rate_ff;
   logic [23:0] atk_ff, dec_ff;
   logic [24:0] hold_ff;
   logic [2:0]  mode_ff;

   logic [15:0] cur_ff, cur_in, sus_ff, sus_in;
   logic [23:0] el_ff, el_in;
   logic signed [31:0] aslope_ff, aslope_in, dslope_ff, dslope_in;
   logic act_ff, act_in, held_ff, held_in;

   logic [1:0]  op_ff;
   logic [15:0] tl_ff;
   logic [7:0]  d_ff;

   // tick pipeline registers
   logic signed [63:0] prod_ff;
   logic [47:0] rt_ff;
   logic [63:0] rtt_ff;
   logic [16:0] e_ff;
   logic [32:0] eterm;
   logic idx_ok_ff;

   logic [23:0] eff_atk;
   logic [24:0] sus_start;
   assign eff_atk = (atk_ff == 24'd0) ? 24'd1 : atk_ff;
   assign sus_start = {1'b0, eff_atk} + {1'b0, dec_ff};

   // slope division: |diff| << 16 / time, sign applied after
   logic signed [16:0] diff;
   logic [16:0] dmag;
   logic dneg, dneg_ff, dsel_ff;
   logic [39:0] num, quo;
   logic [31:0] den;
   logic div_done;
   logic signed [31:0] sat_q;

   always_comb begin
      if (!cmd.div_sel) diff = $signed({1'b0, peak_ff}) - $signed({1'b0, cur_ff});
      else diff = $signed({1'b0, tl_ff}) - $signed({1'b0, peak_ff});
      dneg = diff[16];
      dmag = dneg ? 17'(-diff) : 17'(diff);
      num = {7'd0, dmag, 16'd0};
      den = cmd.div_sel ? {8'd0, dec_ff} : {8'd0, eff_atk};
   end

   adsr_div #(.NUM_BITS(40), .DEN_BITS(32)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(num), .den(den), .done(div_done), .quo(quo)
   );

   always_comb begin
      if (dneg_ff) sat_q = (quo > 40'h80000000) ? 32'sh80000000 : 32'(-quo);
      else sat_q = (quo > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
   end

   assign sts.div_done = div_done;
   assign sts.trig_up = tl_ff > cur_ff;
   assign sts.need_decay = dec_ff != 24'd0;
   assign sts.is_tick = (op_ff == adsr_pkg::OP_TICK) && act_ff;
   assign sts.is_trig = op_ff == adsr_pkg::OP_TRIGGER;

   // tick phase selection
   logic ph_atk, ph_dec;
   logic signed [25:0] off;
   logic signed [31:0] slope;
   assign ph_atk = el_ff < eff_atk;
   assign ph_dec = !ph_atk && ({1'b0, el_ff} < sus_start);
   always_comb begin
      if (ph_atk) begin
         off = $signed({2'b0, el_ff}) + $signed({18'd0, d_ff}) - $signed({2'b0, eff_atk});
         slope = aslope_ff;
      end else begin
         off = $signed({2'b0, el_ff}) - $signed({2'b0, eff_atk});
         slope = dslope_ff;
      end
   end

   // exponential index: rate * t * depth / 4096, depth a power of two
   logic [39:0] rtx;
   logic [39:0] idx_full;
   assign rtx = 40'(rt_ff);
   assign idx_full = rtx >> (12 - XB);

   logic [16:0] exp_rom [adsr_pkg::EXP_TABLE_DEPTH];
   always_comb begin
      for (int k = 0; k < adsr_pkg::EXP_TABLE_DEPTH; k++)
         exp_rom[k] = adsr_pkg::exp_entry(k);
   end

   logic [47:0] rt_full;
   assign rt_full = 48'(rate_ff) * 48'(el_ff);
   assign eterm = 33'(sus_ff) * 33'(e_ff);

   // tick result
   logic signed [47:0] fl;
   logic signed [48:0] acc;
   logic [15:0] clamped;
   logic kill, rel;
   logic [24:0] el_sum;
   logic signed [25:0] hold_end;

   always_comb begin
      fl = 48'(prod_ff >>> 16);
      acc = $signed({33'd0, peak_ff}) + 49'(fl);
      if (acc < 0) clamped = 16'd0;
      else if (acc > 49'sd65535) clamped = 16'hFFFF;
      else clamped = acc[15:0];
      hold_end = $signed({1'b0, sus_start}) + $signed({hold_ff[24], hold_ff});
      el_sum = {1'b0, el_ff} + {17'd0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op;
         tl_ff <= trigger_level;
         d_ff <= tick_length;
      end
      if (cmd.div_start) begin
         dneg_ff <= dneg;
         dsel_ff <= cmd.div_sel;
      end
      if (cmd.mul_step) begin
         prod_ff <= 64'(slope) * 64'(off);
         rt_ff <= rt_full;
         // parabolic release only needs t below 2^20
         rtt_ff <= 64'(rt_ff[35:0]) * 64'(el_ff[19:0]);
         idx_ok_ff <= idx_full < 40'(adsr_pkg::EXP_TABLE_DEPTH);
         e_ff <= exp_rom[idx_full[XB-1:0]];
      end
   end

   always_comb begin
      cur_in = cur_ff;
      sus_in = sus_ff;
      el_in = el_ff;
      aslope_in = aslope_ff;
      dslope_in = dslope_ff;
      act_in = act_ff;
      held_in = held_ff;
      kill = 1'b0;
      rel = 1'b0;
      if (cmd.div_store) begin
         if (dsel_ff) dslope_in = sat_q;
         else begin
            aslope_in = sat_q;
            dslope_in = '0;
         end
      end
      if (cmd.commit) begin
         unique case (op_ff)
            adsr_pkg::OP_TRIGGER: begin
               if (tl_ff > cur_ff) begin
                  sus_in = tl_ff;
                  el_in = '0;
               end
               act_in = 1'b1;
               held_in = 1'b1;
            end
            adsr_pkg::OP_RELEASE: begin
               el_in = '0;
               held_in = 1'b0;
            end
            adsr_pkg::OP_TICK: begin
               if (act_ff) begin
                  if (held_ff) begin
                     if (ph_atk || ph_dec) cur_in = clamped;
                     else begin
                        cur_in = sus_ff;
                        if (!hold_ff[24] && $signed({1'b0, el_ff}) >= hold_end) rel = 1'b1;
                     end
                  end else begin
                     case (mode_ff)
                        adsr_pkg::MODE_EXP: begin
                           if (!idx_ok_ff || eterm[32:16] == 17'd0) kill = 1'b1;
                           else if ({15'd0, floor_ff} + eterm[32:16] > 32'hFFFF)
                              cur_in = 16'hFFFF;
                           else cur_in = floor_ff + eterm[31:16];
                        end
                        adsr_pkg::MODE_PARAB: begin
                           if (el_ff[23:20] != 4'd0 || rtt_ff[63:8] >= 56'(sus_ff)
                               || sus_ff - 16'(rtt_ff[63:8]) <= floor_ff)
                              kill = 1'b1;
                           else cur_in = sus_ff - 16'(rtt_ff[63:8]);
                        end
                        adsr_pkg::MODE_LINEAR: begin
                           if (rt_ff[47:8] >= 40'(sus_ff)
                               || sus_ff - 16'(rt_ff[47:8]) <= floor_ff)
                              kill = 1'b1;
                           else cur_in = sus_ff - 16'(rt_ff[47:8]);
                        end
                        adsr_pkg::MODE_INST: kill = 1'b1;
                        default: ;
                     endcase
                  end
                  if (rel) held_in = 1'b0;
                  if (kill) begin
                     sus_in = '0;
                     cur_in = floor_ff;
                     act_in = 1'b0;
                  end
                  if (rel || kill) el_in = {16'd0, d_ff};
                  else el_in = el_sum[24] ? 24'hFFFFFF : el_sum[23:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= 16'hFFFF;
         floor_ff <= '0;
         atk_ff <= 24'd1;
         dec_ff <= '0;
         hold_ff <= '1;
         rate_ff <= 16'd256;
         mode_ff <= adsr_pkg::MODE_LINEAR;
         cur_ff <= '0;
         sus_ff <= '0;
         el_ff <= '0;
         aslope_ff <= '0;
         dslope_ff <= '0;
         act_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_idx)
               adsr_pkg::REG_PEAK:  peak_ff <= cfg_data[15:0];
               adsr_pkg::REG_FLOOR: floor_ff <= cfg_data[15:0];
               adsr_pkg::REG_ATK:   atk_ff <= cfg_data[23:0];
               adsr_pkg::REG_DEC:   dec_ff <= cfg_data[23:0];
               adsr_pkg::REG_HOLD:  hold_ff <= cfg_data[24:0];
               adsr_pkg::REG_RATE:  rate_ff <= cfg_data[15:0];
               adsr_pkg::REG_MODE:  mode_ff <= cfg_data[2:0];
               default: ;
            endcase
         end
         cur_ff <= cur_in;
         sus_ff <= sus_in;
         el_ff <= el_in;
         aslope_ff <= aslope_in;
         dslope_ff <= dslope_in;
         act_ff <= act_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      unique case (cfg_idx)
         adsr_pkg::REG_PEAK:  cfg_rdata = {16'd0, peak_ff};
         adsr_pkg::REG_FLOOR: cfg_rdata = {16'd0, floor_ff};
         adsr_pkg::REG_ATK:   cfg_rdata = {8'd0, atk_ff};
         adsr_pkg::REG_DEC:   cfg_rdata = {8'd0, dec_ff};
         adsr_pkg::REG_HOLD:  cfg_rdata = {{7{hold_ff[24]}}, hold_ff};
         adsr_pkg::REG_RATE:  cfg_rdata = {16'd0, rate_ff};
         adsr_pkg::REG_MODE:  cfg_rdata = {29'd0, mode_ff};
         default: cfg_rdata = '0;
      endcase
   end

   assign level = act_ff ? cur_ff : floor_ff;
   assign running = act_ff;
   assign holding = held_ff;
endmodule

>>> hw/rtl/adsr_envelope_generator_core.sv
// ADSR envelope generator: one transaction in, one result out, one at a time. A tick of a
// running envelope passes through decode, two arithmetic steps and a commit state before
// its result; a release, an unused op, a tick while stopped or a trigger that does not
// raise the level commits straight from decode. A trigger that raises the level runs the
// shared 40-step restoring divider for the attack slope and again for the decay slope
// when decay time is nonzero. A stalled result holds the core until it is taken.
// depends on adsr_pkg, adsr_ctrl, adsr_dp
`timescale 1ns / 1ps
module adsr_envelope_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata, // op[1:0], trigger_level[17:2], tick_length[25:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata, // level[15:0], running[16], holding[17]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   adsr_pkg::cmd_type cmd;
   adsr_pkg::sts_type sts;
   logic [15:0] level;
   logic running, holding;

   assign csr_pready = 1'b1;

   adsr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd), .sts(sts)
   );

   adsr_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .op(req_tdata[1:0]), .trigger_level(req_tdata[17:2]), .tick_length(req_tdata[25:18]),
      .cfg_we(csr_psel & csr_penable & csr_pwrite), .cfg_idx(csr_paddr[4:2]),
      .cfg_data(csr_pwdata), .cfg_rdata(csr_prdata),
      .level(level), .running(running), .holding(holding)
   );

   assign rsp_tdata = {6'd0, holding, running, level};
   logic unused;
   assign unused = ^{req_tdata[31:26], csr_paddr[1:0]};
endmodule

>>> hw/rtl/adsr_checker.sv
// adsr_checker: port-level properties of the envelope core
// bound to adsr_envelope_generator_core
`timescale 1ns / 1ps
module adsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_result_after: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted twice");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("result changed");
   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
endmodule

bind adsr_envelope_generator_core adsr_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
